// File: rtl/core/mbc_pkg.sv
// Shared constants and types for the cartridge bank controller.
package mbc_pkg;

    localparam int ROM_BYTES = 2097152;
    localparam int RAM_BYTES = 32768;
    localparam int ROM_AW    = $clog2(ROM_BYTES);
    localparam int RAM_AW    = $clog2(RAM_BYTES);

    // Full span of a bank index before wrapping to the store size.
    localparam int ROM_IDX_W = 21;
    localparam int RAM_IDX_W = 15;

    typedef logic [1:0] t_opcode;
    localparam t_opcode OP_READ  = 2'd0;
    localparam t_opcode OP_WRITE = 2'd1;
    localparam t_opcode OP_LOAD  = 2'd2;

    // Source of a read transaction's byte.
    typedef logic [1:0] t_rd_sel;
    localparam t_rd_sel SEL_ROM = 2'd0;
    localparam t_rd_sel SEL_RAM = 2'd1;
    localparam t_rd_sel SEL_FF  = 2'd2;

    localparam logic [7:0] UNMAPPED_BYTE = 8'hFF;
    localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;
    localparam logic [2:0] RAM_WINDOW_TOP = 3'b101; // A000-BFFF

endpackage

// File: rtl/core/mbc1_bank_controller.sv
// Cartridge bank controller: banked ROM/RAM store with bus read, write and ROM load.
//
// Accepts one transaction per clock while o_ready is high: a bus read, a bus
// write (control register or cartridge RAM) or the loading of one ROM byte.
// A bus read produces one byte on the output channel, held first in the
// registered read port of the ROM/RAM stores and then in the output
// register; writes and loads produce nothing. Bank registers update at the
// accepting edge, so the very next transaction already sees the new banking.
// Reads of 0000-3FFF hit ROM bank 0, 4000-7FFF the 7-bit ROM bank, and
// A000-BFFF the 8 KB RAM bank while RAM is enabled (0x?A written to
// 0000-1FFF); everything else reads FF. After reset the RAM is swept to zero
// at one byte a cycle, while o_ready stays low. ROM contents are undefined
// until loaded; reading an unloaded byte returns whatever the store holds.
// Address bits 16-20 are ignored on bus accesses; loads at offsets beyond the
// ROM size are dropped. The input side keeps accepting while a finished byte
// waits on the output, and stalls only during clearing or when both the read
// stage and the output register are full and i_ready is low.
module mbc1_bank_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_opcode,
    input  logic [20:0] i_address,
    input  logic [7:0]  i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_read_data
);

    // Stores
    logic [7:0] rom_mem [mbc_pkg::ROM_BYTES];
    logic [7:0] ram_mem [mbc_pkg::RAM_BYTES];

    // Bank registers
    logic [6:0] r_rom_bank;
    logic [1:0] r_ram_bank;
    logic       r_ram_on;
    logic       r_mode;

    // RAM clearing sweep
    logic                      r_clr_busy;
    logic [mbc_pkg::RAM_AW-1:0] r_clr_addr;

    // Read stage (memory data registered) and output register
    logic                 r_s1_valid;
    mbc_pkg::t_rd_sel     r_s1_sel;
    logic [7:0]           r_rom_q;
    logic [7:0]           r_ram_q;
    logic                 r_out_valid;
    logic [7:0]           r_out_data;

    logic                 accept;
    logic                 s1_adv;
    logic [15:0]          bus_a;
    logic                 is_read;
    logic                 is_write;
    logic                 is_load;
    logic                 in_ram_window;
    logic [mbc_pkg::ROM_IDX_W-1:0] rom_idx_full;
    logic [mbc_pkg::ROM_AW-1:0]    rom_rd_idx;
    logic [mbc_pkg::RAM_IDX_W-1:0] ram_idx_full;
    logic [mbc_pkg::RAM_AW-1:0]    ram_idx;
    logic                 load_in_range;
    logic                 ram_we;
    logic [mbc_pkg::RAM_AW-1:0]    ram_wa;
    logic [7:0]           ram_wd;
    logic                 ram_bus_we;
    mbc_pkg::t_rd_sel     n_sel;
    logic [4:0]           low_bank;
    logic [7:0]           s1_byte;

    // Handshake: apart from clearing, stall only when the read stage holds a byte that cannot move on.
    assign s1_adv  = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_clr_busy && (!r_s1_valid || !r_out_valid || i_ready);
    assign accept  = i_valid && o_ready;

    assign bus_a    = i_address[15:0];
    assign is_read  = (i_opcode == mbc_pkg::OP_READ);
    assign is_write = (i_opcode == mbc_pkg::OP_WRITE);
    assign is_load  = (i_opcode == mbc_pkg::OP_LOAD);

    assign in_ram_window = (bus_a[15:13] == mbc_pkg::RAM_WINDOW_TOP);

    // ROM address: fixed bank 0 below 4000, switchable bank above; wraps to ROM size.
    always_comb begin
        if (!bus_a[14]) begin
            rom_idx_full = {7'd0, bus_a[13:0]};
        end else begin
            rom_idx_full = {r_rom_bank, bus_a[13:0]};
        end
    end
    assign rom_rd_idx = rom_idx_full[mbc_pkg::ROM_AW-1:0];

    assign ram_idx_full = {r_ram_bank, bus_a[12:0]};
    assign ram_idx      = ram_idx_full[mbc_pkg::RAM_AW-1:0];

    assign load_in_range = ({1'b0, i_address} < 22'(mbc_pkg::ROM_BYTES));

    // Read source decode
    always_comb begin
        if (!bus_a[15]) begin
            n_sel = mbc_pkg::SEL_ROM;
        end else if (r_ram_on && in_ram_window) begin
            n_sel = mbc_pkg::SEL_RAM;
        end else begin
            n_sel = mbc_pkg::SEL_FF;
        end
    end

    // RAM write port: sweep during clearing, bus writes afterwards
    assign ram_bus_we = accept && is_write && r_ram_on && in_ram_window;
    assign ram_we     = r_clr_busy || ram_bus_we;
    assign ram_wa     = r_clr_busy ? r_clr_addr : ram_idx;
    assign ram_wd     = r_clr_busy ? 8'd0 : i_data;

    // ROM store: load port and registered read port
    always_ff @(posedge i_clk) begin
        if (accept && is_load && load_in_range) begin
            rom_mem[i_address[mbc_pkg::ROM_AW-1:0]] <= i_data;
        end
        if (accept && is_read && n_sel == mbc_pkg::SEL_ROM) begin
            r_rom_q <= rom_mem[rom_rd_idx];
        end
    end

    // RAM store: one write port, registered read port
    always_ff @(posedge i_clk) begin
        if (ram_we) begin
            ram_mem[ram_wa] <= ram_wd;
        end
        if (accept && is_read && n_sel == mbc_pkg::SEL_RAM) begin
            r_ram_q <= ram_mem[ram_idx];
        end
    end

    // Bank register updates on control-range writes
    assign low_bank = (i_data[4:0] == 5'd0) ? 5'd1 : i_data[4:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom_bank <= 7'd1;
            r_ram_bank <= 2'd0;
            r_ram_on   <= 1'b0;
            r_mode     <= 1'b0;
        end else if (accept && is_write && !bus_a[15]) begin
            case (bus_a[14:13])
                2'd0: begin
                    r_ram_on <= (i_data[3:0] == mbc_pkg::RAM_ENABLE_KEY);
                end
                2'd1: begin
                    r_rom_bank <= {r_rom_bank[6:5], low_bank};
                end
                2'd2: begin
                    if (r_mode) begin
                        r_ram_bank <= i_data[1:0];
                    end else begin
                        r_rom_bank <= {i_data[1:0], r_rom_bank[4:0]};
                    end
                end
                2'd3: begin
                    r_mode <= i_data[0];
                end
                default: begin
                    r_mode <= r_mode;
                end
            endcase
        end
    end

    // Clearing sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (&r_clr_addr) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Read stage: byte source tag travels with the registered memory data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept && is_read) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && is_read) begin
            r_s1_sel <= n_sel;
        end
    end

    always_comb begin
        case (r_s1_sel)
            mbc_pkg::SEL_ROM: s1_byte = r_rom_q;
            mbc_pkg::SEL_RAM: s1_byte = r_ram_q;
            default:          s1_byte = mbc_pkg::UNMAPPED_BYTE;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_data <= s1_byte;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_read_data = r_out_data;

    // Checks
    a_bank_low_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rom_bank[4:0] != 5'd0)
        else $error("ROM bank low bits reached zero");

    a_read_enters_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && is_read |=> r_s1_valid)
        else $error("accepted read transaction lost before read stage");

    a_no_accept_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !accept && !ram_bus_we)
        else $error("transaction accepted during RAM clearing");

    a_sweep_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_clr_busy) |-> r_clr_addr == '0)
        else $error("RAM clearing sweep ended early");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_out_valid && !i_ready |=> r_s1_valid && $stable(r_s1_sel))
        else $error("stalled read stage changed");

endmodule
